FILE: hw/rtl/lcdfb_pkg.sv
// Shared types and constants of the layered character display framebuffer.
`timescale 1ns / 1ps

package lcdfb_pkg;

   // Item function codes
   localparam logic [1:0] FUNC_WRITE  = 2'd0;
   localparam logic [1:0] FUNC_SETPOS = 2'd1;
   localparam logic [1:0] FUNC_FLUSH  = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   // Result kinds
   localparam logic KIND_CHAR   = 1'b0;
   localparam logic KIND_CURSOR = 1'b1;

   // Config register indexes
   localparam logic [2:0] CSR_EMPTY_CODE  = 3'd0;
   localparam logic [2:0] CSR_SKIP_CODE   = 3'd1;
   localparam logic [2:0] CSR_END_CODE    = 3'd2;
   localparam logic [2:0] CSR_FORWARD     = 3'd3;
   localparam logic [2:0] CSR_OVERLAY_EN  = 3'd4;
   localparam logic [2:0] CSR_HOLD_CURSOR = 3'd5;
   localparam logic [2:0] CSR_CURSOR_ROW  = 3'd6;
   localparam logic [2:0] CSR_CURSOR_COL  = 3'd7;

   // Config reset values
   localparam logic [7:0] RST_EMPTY_CODE = 8'd32;
   localparam logic [7:0] RST_SKIP_CODE  = 8'd0;
   localparam logic [7:0] RST_END_CODE   = 8'd1;

   // Display DDRAM set-address instruction opcode bit
   localparam logic [7:0] DDRAM_SET_ADDR = 8'b1000_0000;

   typedef struct packed {
      logic [7:0] empty_code;
      logic [7:0] skip_code;
      logic [7:0] end_code;
      logic       forward_direction;
      logic       overlay_enabled;
      logic       hold_cursor;
      logic [1:0] cursor_row;
      logic [5:0] cursor_column;
   } cfg_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;       // latch an accepted write/setpos/clear word
      logic exec;       // carry out the latched word
      logic walk_init;  // start of a flush
      logic rd;         // read the current cell
      logic ev;         // evaluate the current cell, step the walk
      logic cursor;     // queue the cursor restore result
      logic finish;     // drain the last result, clear dirty bits
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic last_cell;
      logic hold_cursor;
   } sts_type;

   // DDRAM start address of each display row
   function automatic logic [7:0] row_offset(input logic [1:0] r);
      logic [7:0] off;
      case (r)
         2'd0: off = 8'h00;
         2'd1: off = 8'h40;
         2'd2: off = 8'h14;
         2'd3: off = 8'h54;
         default: off = 8'h00;
      endcase
      return off;
   endfunction

endpackage

FILE: hw/rtl/lcdfb_ctrl.sv
// Sequencing state machine of the framebuffer: item dispatch and flush walk.
`timescale 1ns / 1ps

module lcdfb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_func,
   output logic              busy,
   output lcdfb_pkg::cmd_type cmd,
   input  lcdfb_pkg::sts_type sts
);
   import lcdfb_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_EXEC   = 6'b000010,
      ST_FL_RD  = 6'b000100,
      ST_FL_EV  = 6'b001000,
      ST_FL_CUR = 6'b010000,
      ST_FL_END = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_func == FUNC_FLUSH) ? ST_FL_RD : ST_EXEC;
            end
         end
         ST_EXEC:   state_in = ST_IDLE;
         ST_FL_RD:  state_in = ST_FL_EV;
         ST_FL_EV: begin
            if (sts.last_cell) begin
               state_in = sts.hold_cursor ? ST_FL_CUR : ST_FL_END;
            end else begin
               state_in = ST_FL_RD;
            end
         end
         ST_FL_CUR: state_in = ST_FL_END;
         ST_FL_END: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands to the datapath
   always_comb begin
      cmd           = '0;
      cmd.load      = accept && (req_func != FUNC_FLUSH);
      cmd.walk_init = accept && (req_func == FUNC_FLUSH);
      cmd.exec      = (state_ff == ST_EXEC);
      cmd.rd        = (state_ff == ST_FL_RD);
      cmd.ev        = (state_ff == ST_FL_EV);
      cmd.cursor    = (state_ff == ST_FL_CUR);
      cmd.finish    = (state_ff == ST_FL_END);
   end

   // A flush always closes and returns to idle
   a_end_to_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FL_END |=> state_ff == ST_IDLE)
      else $error("flush end did not return to idle");

   // An accepted flush starts the walk with a cell read
   a_flush_starts: assert property (@(posedge clock) disable iff (reset)
      accept && req_func == FUNC_FLUSH |=> state_ff == ST_FL_RD)
      else $error("accepted flush did not start the walk");

endmodule

FILE: hw/rtl/lcdfb_dpath.sv
// Datapath: cell memories, write position, flush walk and result register.
`timescale 1ns / 1ps

module lcdfb_dpath #(
   parameter int ROWS    = 2,
   parameter int COLUMNS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_func,
   input  logic               req_layer,
   input  logic [1:0]         req_row,
   input  logic [5:0]         req_column,
   input  logic [7:0]         req_char_code,
   input  lcdfb_pkg::cfg_type cfg,
   input  lcdfb_pkg::cmd_type cmd,
   output lcdfb_pkg::sts_type sts,
   output logic               rsp_strobe,
   output logic               rsp_kind,
   output logic [7:0]         rsp_address_instruction,
   output logic [7:0]         rsp_char_code_res,
   output logic               rsp_last
);
   import lcdfb_pkg::*;

   localparam int         CELLS    = ROWS * COLUMNS;
   localparam int         IDX_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam logic [5:0] COL_LAST = 6'(COLUMNS - 1);
   localparam logic [1:0] ROW_LAST = 2'(ROWS - 1);

   // Constant modulo tables for the position arithmetic
   logic [5:0] col_mod_tab [64];
   logic [1:0] row_mod_tab [4];
   logic [1:0] row_inc_tab [4];
   logic [1:0] row_dec_tab [4];

   for (genvar gk = 0; gk < 64; gk++) begin : g_col_tab
      assign col_mod_tab[gk] = 6'(gk % COLUMNS);
   end
   for (genvar gr = 0; gr < 4; gr++) begin : g_row_tab
      assign row_mod_tab[gr] = 2'(gr % ROWS);
      assign row_inc_tab[gr] = 2'((gr + 1) % ROWS);
      assign row_dec_tab[gr] = 2'((gr + ROWS - 1) % ROWS);
   end

   // Latched item
   logic [1:0] item_func_ff,  item_func_in;
   logic       item_layer_ff, item_layer_in;
   logic [1:0] item_row_ff,   item_row_in;
   logic [5:0] item_col_ff,   item_col_in;
   logic [7:0] item_code_ff,  item_code_in;

   // Write position and clear snapshot
   logic [1:0] wrow_ff, wrow_in;
   logic [5:0] wcol_ff, wcol_in;
   logic [7:0] clr_empty_ff, clr_empty_in;
   logic [7:0] clr_skip_ff,  clr_skip_in;

   // Per-cell flags
   logic [CELLS-1:0] uval_ff,  uval_in;
   logic [CELLS-1:0] oval_ff,  oval_in;
   logic [CELLS-1:0] dirty_ff, dirty_in;

   // Flush walk
   logic [1:0]       walk_row_ff, walk_row_in;
   logic [5:0]       walk_col_ff, walk_col_in;
   logic [IDX_W-1:0] walk_idx_ff, walk_idx_in;
   logic             uend_ff, uend_in;
   logic             oend_ff, oend_in;
   logic             uv_rd_ff, uv_rd_in;
   logic             ov_rd_ff, ov_rd_in;
   logic             dt_rd_ff, dt_rd_in;
   logic [7:0]       u_rdata_ff;
   logic [7:0]       o_rdata_ff;

   // One-deep hold so the final result can carry last
   logic       hold_vld_ff,  hold_vld_in;
   logic       hold_kind_ff, hold_kind_in;
   logic [7:0] hold_addr_ff, hold_addr_in;
   logic [7:0] hold_code_ff, hold_code_in;

   // Result register
   logic       rsp_strobe_ff, rsp_strobe_in;
   logic       rsp_kind_ff,   rsp_kind_in;
   logic [7:0] rsp_addr_ff,   rsp_addr_in;
   logic [7:0] rsp_code_ff,   rsp_code_in;
   logic       rsp_last_ff,   rsp_last_in;

   // Cell memories
   logic [7:0] user_mem [CELLS];
   logic [7:0] ovl_mem  [CELLS];

   logic [1:0]       r0, r1;
   logic [5:0]       c0, c1;
   logic [IDX_W-1:0] widx;
   logic             to_overlay;
   logic             do_write;
   logic [7:0]       us, ov;
   logic             emit, set_uend, set_oend;
   logic [7:0]       emit_code;
   logic [7:0]       walk_off, cur_off;
   logic [7:0]       walk_addr, cur_addr;
   logic             push;
   logic             new_kind;
   logic [7:0]       new_addr, new_code;

   // Write position: wrap the column, find the cell, step one cell
   always_comb begin
      if (wcol_ff > COL_LAST) begin
         r0 = row_inc_tab[wrow_ff];
         c0 = col_mod_tab[wcol_ff];
      end else begin
         r0 = wrow_ff;
         c0 = wcol_ff;
      end
      widx = IDX_W'(32'(row_mod_tab[r0]) * COLUMNS + 32'(c0));
      if (cfg.forward_direction) begin
         if (c0 == COL_LAST) begin
            r1 = row_inc_tab[r0];
            c1 = '0;
         end else begin
            r1 = r0;
            c1 = c0 + 6'd1;
         end
      end else begin
         if (c0 == '0) begin
            r1 = row_dec_tab[r0];
            c1 = COL_LAST;
         end else begin
            r1 = r0;
            c1 = c0 - 6'd1;
         end
      end
   end

   assign to_overlay = item_layer_ff && cfg.overlay_enabled;
   assign do_write   = cmd.exec && (item_func_ff == FUNC_WRITE);

   // Cell evaluation during the flush
   always_comb begin
      us        = uv_rd_ff ? u_rdata_ff : clr_empty_ff;
      ov        = cfg.overlay_enabled ? (ov_rd_ff ? o_rdata_ff : clr_skip_ff)
                                      : cfg.skip_code;
      emit      = 1'b0;
      emit_code = cfg.empty_code;
      set_uend  = 1'b0;
      set_oend  = 1'b0;
      if (oend_ff) begin
         emit = 1'b1;
      end else if (!dt_rd_ff && !uend_ff) begin
         emit = 1'b0;
      end else if (ov == cfg.end_code) begin
         set_oend = 1'b1;
         emit     = 1'b1;
      end else if (ov == cfg.skip_code) begin
         if (uend_ff) begin
            emit = 1'b1;
         end else if (us == cfg.end_code) begin
            set_uend = 1'b1;
            emit     = 1'b1;
         end else if (us != cfg.skip_code) begin
            emit      = 1'b1;
            emit_code = us;
         end
      end else begin
         emit      = 1'b1;
         emit_code = ov;
      end
   end

   // Set-address bytes: row offset plus column, wrapped in 7 bits
   assign walk_off  = row_offset(walk_row_ff);
   assign cur_off   = row_offset(row_mod_tab[cfg.cursor_row]);
   assign walk_addr = DDRAM_SET_ADDR
                    | {1'b0, 7'({1'b0, walk_col_ff} + walk_off[6:0])};
   assign cur_addr  = DDRAM_SET_ADDR
                    | {1'b0, 7'({1'b0, cfg.cursor_column} + cur_off[6:0])};

   assign push     = (cmd.ev && emit) || cmd.cursor;
   assign new_kind = cmd.cursor ? KIND_CURSOR : KIND_CHAR;
   assign new_addr = cmd.cursor ? cur_addr : walk_addr;
   assign new_code = cmd.cursor ? 8'd0 : emit_code;

   // Next-state logic
   always_comb begin
      item_func_in  = item_func_ff;
      item_layer_in = item_layer_ff;
      item_row_in   = item_row_ff;
      item_col_in   = item_col_ff;
      item_code_in  = item_code_ff;
      wrow_in       = wrow_ff;
      wcol_in       = wcol_ff;
      clr_empty_in  = clr_empty_ff;
      clr_skip_in   = clr_skip_ff;
      uval_in       = uval_ff;
      oval_in       = oval_ff;
      dirty_in      = dirty_ff;
      walk_row_in   = walk_row_ff;
      walk_col_in   = walk_col_ff;
      walk_idx_in   = walk_idx_ff;
      uend_in       = uend_ff;
      oend_in       = oend_ff;
      uv_rd_in      = uv_rd_ff;
      ov_rd_in      = ov_rd_ff;
      dt_rd_in      = dt_rd_ff;
      hold_vld_in   = hold_vld_ff;
      hold_kind_in  = hold_kind_ff;
      hold_addr_in  = hold_addr_ff;
      hold_code_in  = hold_code_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_last_in   = 1'b0;

      // accepted word
      if (cmd.load) begin
         item_func_in  = req_func;
         item_layer_in = req_layer;
         item_row_in   = req_row;
         item_col_in   = req_column;
         item_code_in  = req_char_code;
      end

      // write, set position, clear
      if (cmd.exec) begin
         case (item_func_ff)
            FUNC_WRITE: begin
               if (to_overlay) begin
                  oval_in[widx] = 1'b1;
               end else begin
                  uval_in[widx] = 1'b1;
               end
               dirty_in[widx] = 1'b1;
               wrow_in        = r1;
               wcol_in        = c1;
            end
            FUNC_SETPOS: begin
               wrow_in = item_row_ff;
               wcol_in = item_col_ff;
            end
            FUNC_CLEAR: begin
               uval_in      = '0;
               oval_in      = '0;
               dirty_in     = '0;
               clr_empty_in = cfg.empty_code;
               clr_skip_in  = cfg.skip_code;
            end
            default: begin
               wrow_in = wrow_ff;
            end
         endcase
      end

      // flush walk
      if (cmd.walk_init) begin
         walk_row_in = '0;
         walk_col_in = '0;
         walk_idx_in = '0;
         uend_in     = 1'b0;
         oend_in     = 1'b0;
         hold_vld_in = 1'b0;
      end

      if (cmd.rd) begin
         uv_rd_in = uval_ff[walk_idx_ff];
         ov_rd_in = oval_ff[walk_idx_ff];
         dt_rd_in = dirty_ff[walk_idx_ff];
      end

      if (cmd.ev) begin
         walk_idx_in = walk_idx_ff + 1'b1;
         if (walk_col_ff == COL_LAST) begin
            walk_col_in = '0;
            walk_row_in = walk_row_ff + 2'd1;
            uend_in     = 1'b0;
            oend_in     = 1'b0;
         end else begin
            walk_col_in = walk_col_ff + 6'd1;
            uend_in     = uend_ff || set_uend;
            oend_in     = oend_ff || set_oend;
         end
      end

      // result hold and output
      if (push) begin
         if (hold_vld_ff) begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = hold_kind_ff;
            rsp_addr_in   = hold_addr_ff;
            rsp_code_in   = hold_code_ff;
         end
         hold_vld_in  = 1'b1;
         hold_kind_in = new_kind;
         hold_addr_in = new_addr;
         hold_code_in = new_code;
      end

      if (cmd.finish) begin
         if (hold_vld_ff) begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = hold_kind_ff;
            rsp_addr_in   = hold_addr_ff;
            rsp_code_in   = hold_code_ff;
            rsp_last_in   = 1'b1;
         end
         hold_vld_in = 1'b0;
         dirty_in    = '0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wrow_ff       <= '0;
         wcol_ff       <= '0;
         clr_empty_ff  <= RST_EMPTY_CODE;
         clr_skip_ff   <= RST_SKIP_CODE;
         uval_ff       <= '0;
         oval_ff       <= '0;
         dirty_ff      <= '0;
         uend_ff       <= 1'b0;
         oend_ff       <= 1'b0;
         hold_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         wrow_ff       <= wrow_in;
         wcol_ff       <= wcol_in;
         clr_empty_ff  <= clr_empty_in;
         clr_skip_ff   <= clr_skip_in;
         uval_ff       <= uval_in;
         oval_ff       <= oval_in;
         dirty_ff      <= dirty_in;
         uend_ff       <= uend_in;
         oend_ff       <= oend_in;
         hold_vld_ff   <= hold_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_func_ff  <= item_func_in;
      item_layer_ff <= item_layer_in;
      item_row_ff   <= item_row_in;
      item_col_ff   <= item_col_in;
      item_code_ff  <= item_code_in;
      walk_row_ff   <= walk_row_in;
      walk_col_ff   <= walk_col_in;
      walk_idx_ff   <= walk_idx_in;
      uv_rd_ff      <= uv_rd_in;
      ov_rd_ff      <= ov_rd_in;
      dt_rd_ff      <= dt_rd_in;
      hold_kind_ff  <= hold_kind_in;
      hold_addr_ff  <= hold_addr_in;
      hold_code_ff  <= hold_code_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_code_ff   <= rsp_code_in;
   end

   // User layer memory
   always_ff @(posedge clock) begin
      if (do_write && !to_overlay) begin
         user_mem[widx] <= item_code_ff;
      end
      if (cmd.rd) begin
         u_rdata_ff <= user_mem[walk_idx_ff];
      end
   end

   // Overlay layer memory
   always_ff @(posedge clock) begin
      if (do_write && to_overlay) begin
         ovl_mem[widx] <= item_code_ff;
      end
      if (cmd.rd) begin
         o_rdata_ff <= ovl_mem[walk_idx_ff];
      end
   end

   assign sts.last_cell   = (walk_row_ff == ROW_LAST) && (walk_col_ff == COL_LAST);
   assign sts.hold_cursor = cfg.hold_cursor;

   assign rsp_strobe              = rsp_strobe_ff;
   assign rsp_kind                = rsp_kind_ff;
   assign rsp_address_instruction = rsp_addr_ff;
   assign rsp_char_code_res       = rsp_code_ff;
   assign rsp_last                = rsp_last_ff;

   // last only ever marks a real result word
   a_last_has_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last_ff |-> rsp_strobe_ff)
      else $error("last without result strobe");

   // the cursor restore is always the closing word of a flush
   a_cursor_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_kind_ff == KIND_CURSOR |-> rsp_last_ff && rsp_code_ff == 8'd0)
      else $error("cursor restore not closing the flush");

   // every result word carries a set-address instruction
   a_addr_opcode: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> rsp_addr_ff[7])
      else $error("result address lacks set-address opcode");

endmodule

FILE: hw/rtl/layered_char_display_framebuffer.sv
// Top level: config registers, controller and datapath of the framebuffer.
`timescale 1ns / 1ps

// Character display framebuffer with a user layer, an overlay layer and a
// dirty bit per cell. A word is taken when start is high and busy is low.
// Write, set-position and clear words pass through ST_EXEC and give no
// result. A flush walks every cell, then ST_FL_CUR when the cursor restore
// is on, then ST_FL_END: each cell is read from the cell memories in
// ST_FL_RD and judged in ST_FL_EV. Results leave one word per strobe with
// no back pressure; the closing words of a flush can come back to back, and
// the final one, marked by rsp_last, shows up as busy drops. A flush with
// nothing to show and no cursor restore gives none.
// Cells are cleared at once by reset or a clear word; no sweep is needed.
// Config writes are meant for idle periods only.
module layered_char_display_framebuffer #(
   parameter int ROWS    = 2,
   parameter int COLUMNS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_func,
   input  logic       req_layer,
   input  logic [1:0] req_row,
   input  logic [5:0] req_column,
   input  logic [7:0] req_char_code,
   output logic       rsp_strobe,
   output logic       rsp_kind,
   output logic [7:0] rsp_address_instruction,
   output logic [7:0] rsp_char_code_res,
   output logic       rsp_last,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import lcdfb_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   sts_type sts;

   // Config register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_EMPTY_CODE:  cfg_in.empty_code        = csr_wdata;
            CSR_SKIP_CODE:   cfg_in.skip_code         = csr_wdata;
            CSR_END_CODE:    cfg_in.end_code          = csr_wdata;
            CSR_FORWARD:     cfg_in.forward_direction = csr_wdata[0];
            CSR_OVERLAY_EN:  cfg_in.overlay_enabled   = csr_wdata[0];
            CSR_HOLD_CURSOR: cfg_in.hold_cursor       = csr_wdata[0];
            CSR_CURSOR_ROW:  cfg_in.cursor_row        = csr_wdata[1:0];
            CSR_CURSOR_COL:  cfg_in.cursor_column     = csr_wdata[5:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.empty_code        <= RST_EMPTY_CODE;
         cfg_ff.skip_code         <= RST_SKIP_CODE;
         cfg_ff.end_code          <= RST_END_CODE;
         cfg_ff.forward_direction <= 1'b1;
         cfg_ff.overlay_enabled   <= 1'b1;
         cfg_ff.hold_cursor       <= 1'b0;
         cfg_ff.cursor_row        <= '0;
         cfg_ff.cursor_column     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcdfb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .busy     (busy),
      .cmd      (cmd),
      .sts      (sts)
   );

   lcdfb_dpath #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_dpath (
      .clock                   (clock),
      .reset                   (reset),
      .req_func                (req_func),
      .req_layer               (req_layer),
      .req_row                 (req_row),
      .req_column              (req_column),
      .req_char_code           (req_char_code),
      .cfg                     (cfg_ff),
      .cmd                     (cmd),
      .sts                     (sts),
      .rsp_strobe              (rsp_strobe),
      .rsp_kind                (rsp_kind),
      .rsp_address_instruction (rsp_address_instruction),
      .rsp_char_code_res       (rsp_char_code_res),
      .rsp_last                (rsp_last)
   );

endmodule

FILE: tb/lcdfb_flush_check.sv
// Prediction and comparison of framebuffer display writes, watching the block's ports.
`timescale 1ns / 1ps

module lcdfb_flush_check #(
   parameter int ROWS    = 2,
   parameter int COLUMNS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic [1:0] req_func,
   input  logic       req_layer,
   input  logic [1:0] req_row,
   input  logic [5:0] req_column,
   input  logic [7:0] req_char_code,
   input  logic       rsp_strobe,
   input  logic       rsp_kind,
   input  logic [7:0] rsp_address_instruction,
   input  logic [7:0] rsp_char_code_res,
   input  logic       rsp_last,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata,
   output int         errors,
   output int         due_count,
   output int         words_taken,
   output int         flushes_taken,
   output int         writes_checked
);
   import lcdfb_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;

   typedef struct packed {
      logic       kind;
      logic [7:0] addr;
      logic [7:0] code;
      logic       last;
   } disp_write_type;

   // Display writes predicted but not yet seen, oldest first
   disp_write_type writes_due[$];

   // Shadow of the block's state and registers
   logic [7:0] user_cell [0:CELLS-1];
   logic [7:0] over_cell [0:CELLS-1];
   logic       dirty     [0:CELLS-1];
   int         wr_row, wr_col;
   cfg_type    cfg;

   disp_write_type got_w, exp_w;

   // Set-address instruction for a cell; row wraps on the display, sum in 7 bits
   function automatic logic [7:0] ddram_addr(input int col, input int r);
      logic [7:0] base;
      logic [7:0] sum;
      case ((r % ROWS) & 3)
         0: base = 8'h00;
         1: base = 8'h40;
         2: base = 8'h14;
         default: base = 8'h54;
      endcase
      sum = 8'(col) + base;
      return DDRAM_SET_ADDR | {1'b0, sum[6:0]};
   endfunction

   function automatic disp_write_type char_write(input int col, input int r,
                                                 input logic [7:0] code);
      disp_write_type w;
      w.kind = KIND_CHAR;
      w.addr = ddram_addr(col, r);
      w.code = code;
      w.last = 1'b0;
      return w;
   endfunction

   task automatic clear_layers();
      int i;
      for (i = 0; i < CELLS; i++) begin
         user_cell[i] = cfg.empty_code;
         over_cell[i] = cfg.skip_code;
         dirty[i]     = 1'b0;
      end
   endtask

   // Move the write position, wrapping through the rows
   task automatic step_position(input int delta);
      int c;
      if (!cfg.forward_direction) delta = -delta;
      c = wr_col + delta;
      if (c >= COLUMNS) begin
         wr_row = (wr_row + 1) % ROWS;
         wr_col = c % COLUMNS;
      end else if (c < 0) begin
         wr_row = (wr_row + ROWS - 1) % ROWS;
         wr_col = c + COLUMNS;
      end else begin
         wr_col = c;
      end
   endtask

   // Walk every cell and queue the display writes of one flush
   task automatic expand_flush();
      disp_write_type batch[$];
      disp_write_type w;
      logic           user_end, over_end;
      logic [7:0]     ov, us;
      int             r, c, idx, i;
      for (r = 0; r < ROWS; r++) begin
         user_end = 1'b0;
         over_end = 1'b0;
         for (c = 0; c < COLUMNS; c++) begin
            idx = r * COLUMNS + c;
            if (over_end) begin
               batch.push_back(char_write(c, r, cfg.empty_code));
            end else if (dirty[idx] || user_end) begin
               ov = cfg.overlay_enabled ? over_cell[idx] : cfg.skip_code;
               if (ov == cfg.end_code) begin
                  over_end = 1'b1;
                  batch.push_back(char_write(c, r, cfg.empty_code));
               end else if (ov == cfg.skip_code) begin
                  // overlay transparent here: user layer decides
                  if (user_end) begin
                     batch.push_back(char_write(c, r, cfg.empty_code));
                  end else begin
                     us = user_cell[idx];
                     if (us == cfg.end_code) begin
                        user_end = 1'b1;
                        batch.push_back(char_write(c, r, cfg.empty_code));
                     end else if (us != cfg.skip_code) begin
                        batch.push_back(char_write(c, r, us));
                     end
                  end
               end else begin
                  batch.push_back(char_write(c, r, ov));
               end
            end
         end
      end
      if (cfg.hold_cursor) begin
         w.kind = KIND_CURSOR;
         w.addr = ddram_addr(int'(cfg.cursor_column), int'(cfg.cursor_row));
         w.code = 8'h00;
         w.last = 1'b0;
         batch.push_back(w);
      end
      for (i = 0; i < batch.size(); i++) begin
         w = batch[i];
         w.last = (i == batch.size() - 1);
         writes_due.push_back(w);
      end
      for (i = 0; i < CELLS; i++) dirty[i] = 1'b0;
   endtask

   // Update the shadow state for one accepted word
   task automatic apply_word();
      int idx;
      case (req_func)
         FUNC_WRITE: begin
            step_position(0);
            idx = (wr_row * COLUMNS + wr_col) % CELLS;
            if (req_layer && cfg.overlay_enabled) over_cell[idx] = req_char_code;
            else user_cell[idx] = req_char_code;
            dirty[idx] = 1'b1;
            step_position(1);
         end
         FUNC_SETPOS: begin
            wr_row = int'(req_row);
            wr_col = int'(req_column);
         end
         FUNC_FLUSH: begin
            expand_flush();
            flushes_taken++;
         end
         default: clear_layers();
      endcase
   endtask

   task automatic apply_csr();
      case (csr_index)
         CSR_EMPTY_CODE:  cfg.empty_code        = csr_wdata;
         CSR_SKIP_CODE:   cfg.skip_code         = csr_wdata;
         CSR_END_CODE:    cfg.end_code          = csr_wdata;
         CSR_FORWARD:     cfg.forward_direction = csr_wdata[0];
         CSR_OVERLAY_EN:  cfg.overlay_enabled   = csr_wdata[0];
         CSR_HOLD_CURSOR: cfg.hold_cursor       = csr_wdata[0];
         CSR_CURSOR_ROW:  cfg.cursor_row        = csr_wdata[1:0];
         default:         cfg.cursor_column     = csr_wdata[5:0];
      endcase
   endtask

   initial begin
      errors         = 0;
      due_count      = 0;
      words_taken    = 0;
      flushes_taken  = 0;
      writes_checked = 0;
   end

   // Results first (they belong to earlier words), then register and word updates
   always @(posedge clock) begin
      if (reset) begin
         cfg.empty_code        = RST_EMPTY_CODE;
         cfg.skip_code         = RST_SKIP_CODE;
         cfg.end_code          = RST_END_CODE;
         cfg.forward_direction = 1'b1;
         cfg.overlay_enabled   = 1'b1;
         cfg.hold_cursor       = 1'b0;
         cfg.cursor_row        = 2'd0;
         cfg.cursor_column     = 6'd0;
         wr_row = 0;
         wr_col = 0;
         clear_layers();
         writes_due.delete();
      end else begin
         if (rsp_strobe) begin
            got_w.kind = rsp_kind;
            got_w.addr = rsp_address_instruction;
            got_w.code = rsp_char_code_res;
            got_w.last = rsp_last;
            writes_checked++;
            if (writes_due.size() == 0) begin
               errors++;
               $display("%0t: display write with none due: expected nothing, got",
                        $time);
               $display("   kind %0d addr %02h code %02h last %0d",
                        got_w.kind, got_w.addr, got_w.code, got_w.last);
            end else begin
               exp_w = writes_due.pop_front();
               if (got_w !== exp_w) begin
                  errors++;
                  $display("%0t: display write mismatch:", $time);
                  $display("   expected kind %0d addr %02h code %02h last %0d",
                           exp_w.kind, exp_w.addr, exp_w.code, exp_w.last);
                  $display("   got      kind %0d addr %02h code %02h last %0d",
                           got_w.kind, got_w.addr, got_w.code, got_w.last);
               end
            end
         end
         if (csr_we) apply_csr();
         if (start && !busy) begin
            apply_word();
            words_taken++;
         end
      end
      due_count = writes_due.size();
   end

endmodule

FILE: tb/tb_layered_char_display_framebuffer.sv
// Testbench top: clock, reset, word and register stimulus, and the verdict.
`timescale 1ns / 1ps

module tb_layered_char_display_framebuffer;
   import lcdfb_pkg::*;

   localparam int ROWS    = 2;
   localparam int COLUMNS = 16;
   // a flush with nothing to show still walks every cell
   localparam int DRAIN_CYCLES = 2 * ROWS * COLUMNS + 16;
   localparam int PHASES = 8;
   localparam int PHASE_WORDS = 26;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_func;
   logic       req_layer;
   logic [1:0] req_row;
   logic [5:0] req_column;
   logic [7:0] req_char_code;
   logic       rsp_strobe;
   logic       rsp_kind;
   logic [7:0] rsp_address_instruction;
   logic [7:0] rsp_char_code_res;
   logic       rsp_last;
   logic       csr_we;
   logic [2:0] csr_index;
   logic [7:0] csr_wdata;

   int errors, due_count, words_taken, flushes_taken, writes_checked;
   int settings_done;
   bit burst;

   // codes of the current setting, to steer written codes at the special values
   logic [7:0] cur_empty, cur_skip, cur_end;

   layered_char_display_framebuffer #(.ROWS(ROWS), .COLUMNS(COLUMNS)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_layer(req_layer), .req_row(req_row),
      .req_column(req_column), .req_char_code(req_char_code),
      .rsp_strobe(rsp_strobe), .rsp_kind(rsp_kind),
      .rsp_address_instruction(rsp_address_instruction),
      .rsp_char_code_res(rsp_char_code_res), .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   lcdfb_flush_check #(.ROWS(ROWS), .COLUMNS(COLUMNS)) flush_check (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_layer(req_layer), .req_row(req_row),
      .req_column(req_column), .req_char_code(req_char_code),
      .rsp_strobe(rsp_strobe), .rsp_kind(rsp_kind),
      .rsp_address_instruction(rsp_address_instruction),
      .rsp_char_code_res(rsp_char_code_res), .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .due_count(due_count), .words_taken(words_taken),
      .flushes_taken(flushes_taken), .writes_checked(writes_checked)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Present one word at the falling edge and hold it until taken
   task automatic issue_word(input logic [1:0] f, input logic l, input logic [1:0] r,
                             input logic [5:0] c, input logic [7:0] code);
      @(negedge clock);
      start         = 1'b1;
      req_func      = f;
      req_layer     = l;
      req_row       = r;
      req_column    = c;
      req_char_code = code;
      do @(posedge clock); while (busy);
   endtask

   // Idle the input side for a random stretch, mostly short
   task automatic random_gap();
      int sel, n;
      sel = $urandom_range(0, 99);
      if (burst || sel < 50) n = 0;
      else if (sel < 90) n = $urandom_range(1, 3);
      else n = $urandom_range(8, 40);
      if (n > 0) begin
         @(negedge clock);
         start         = 1'b0;
         req_func      = 2'($urandom);
         req_layer     = 1'($urandom);
         req_row       = 2'($urandom);
         req_column    = 6'($urandom);
         req_char_code = 8'($urandom);
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Hold off until every predicted display write has arrived
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (due_count != 0) @(negedge clock);
   endtask

   task automatic put_reg(input logic [2:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // Reprogram every register once the block has gone quiet
   task automatic set_config(input logic [7:0] e, input logic [7:0] s, input logic [7:0] n,
                             input logic f, input logic o, input logic h,
                             input logic [1:0] cr, input logic [5:0] cc);
      logic [7:0] junk;
      drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      junk = 8'($urandom);
      put_reg(CSR_EMPTY_CODE, e);
      put_reg(CSR_SKIP_CODE, s);
      put_reg(CSR_END_CODE, n);
      // unused upper bits carry noise; only the low bits count
      put_reg(CSR_FORWARD, {junk[6:0], f});
      junk = 8'($urandom);
      put_reg(CSR_OVERLAY_EN, {junk[6:0], o});
      junk = 8'($urandom);
      put_reg(CSR_HOLD_CURSOR, {junk[6:0], h});
      junk = 8'($urandom);
      put_reg(CSR_CURSOR_ROW, {junk[5:0], cr});
      junk = 8'($urandom);
      put_reg(CSR_CURSOR_COL, {junk[1:0], cc});
      cur_empty = e;
      cur_skip  = s;
      cur_end   = n;
      settings_done++;
   endtask

   function automatic logic [7:0] pick_code();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 15) return cur_skip;
      if (sel < 25) return cur_end;
      if (sel < 35) return cur_empty;
      return 8'($urandom_range(0, 255));
   endfunction

   // One random word, mostly writes with occasional flushes
   task automatic random_word();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
         issue_word(FUNC_WRITE, 1'($urandom), 2'($urandom), 6'($urandom), pick_code());
      end else if (sel < 75) begin
         if ($urandom_range(0, 4) != 0)
            issue_word(FUNC_SETPOS, 1'($urandom), 2'($urandom_range(0, ROWS - 1)),
                       6'($urandom_range(0, COLUMNS - 1)), 8'($urandom));
         else
            issue_word(FUNC_SETPOS, 1'($urandom), 2'($urandom), 6'($urandom),
                       8'($urandom));
      end else if (sel < 90) begin
         if ($urandom_range(0, 3) == 0) drain();
         issue_word(FUNC_FLUSH, 1'($urandom), 2'($urandom), 6'($urandom), 8'($urandom));
      end else if (sel < 95) begin
         issue_word(FUNC_CLEAR, 1'($urandom), 2'($urandom), 6'($urandom), 8'($urandom));
      end else begin
         issue_word(2'($urandom), 1'($urandom), 2'($urandom), 6'($urandom),
                    8'($urandom));
      end
   endtask

   initial begin
      int p, i, guard;
      reset         = 1'b1;
      start         = 1'b0;
      req_func      = FUNC_WRITE;
      req_layer     = 1'b0;
      req_row       = 2'd0;
      req_column    = 6'd0;
      req_char_code = 8'd0;
      csr_we        = 1'b0;
      csr_index     = CSR_EMPTY_CODE;
      csr_wdata     = 8'd0;
      cur_empty     = RST_EMPTY_CODE;
      cur_skip      = RST_SKIP_CODE;
      cur_end       = RST_END_CODE;
      settings_done = 0;
      burst         = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset setting, layers, wraps, end markers, clear
      issue_word(FUNC_FLUSH, 1'b0, 2'd0, 6'd0, 8'd0);       // nothing to show
      issue_word(FUNC_WRITE, 1'b0, 2'd0, 6'd0, 8'h41);
      issue_word(FUNC_WRITE, 1'b0, 2'd3, 6'd63, 8'hFF);
      issue_word(FUNC_WRITE, 1'b1, 2'd0, 6'd0, 8'h5A);      // overlay wins
      issue_word(FUNC_WRITE, 1'b1, 2'd0, 6'd0, 8'h00);      // overlay skip
      issue_word(FUNC_SETPOS, 1'b1, 2'd3, 6'd63, 8'hFF);    // off the display
      issue_word(FUNC_WRITE, 1'b0, 2'd0, 6'd0, 8'h80);
      issue_word(FUNC_SETPOS, 1'b0, 2'd1, 6'd15, 8'h00);
      issue_word(FUNC_WRITE, 1'b0, 2'd0, 6'd0, 8'h42);      // wraps to row 0
      issue_word(FUNC_WRITE, 1'b0, 2'd0, 6'd0, 8'h43);
      issue_word(FUNC_SETPOS, 1'b0, 2'd1, 6'd4, 8'h00);
      issue_word(FUNC_WRITE, 1'b0, 2'd0, 6'd0, 8'h01);      // user end marker
      issue_word(FUNC_WRITE, 1'b0, 2'd0, 6'd0, 8'h44);
      issue_word(FUNC_SETPOS, 1'b0, 2'd0, 6'd8, 8'h00);
      issue_word(FUNC_WRITE, 1'b1, 2'd0, 6'd0, 8'h01);      // overlay end marker
      issue_word(FUNC_WRITE, 1'b0, 2'd0, 6'd0, 8'h45);
      issue_word(FUNC_FLUSH, 1'b0, 2'd0, 6'd0, 8'h00);
      issue_word(FUNC_CLEAR, 1'b0, 2'd0, 6'd0, 8'h00);
      issue_word(FUNC_FLUSH, 1'b0, 2'd0, 6'd0, 8'h00);

      // Leftward, overlay off, cursor restore outside the display
      set_config(8'd32, 8'd0, 8'd1, 1'b0, 1'b0, 1'b1, 2'd3, 6'd63);
      issue_word(FUNC_WRITE, 1'b1, 2'd0, 6'd0, 8'h33);      // lands in user layer
      issue_word(FUNC_WRITE, 1'b0, 2'd0, 6'd0, 8'h34);
      issue_word(FUNC_FLUSH, 1'b0, 2'd0, 6'd0, 8'h00);
      issue_word(FUNC_FLUSH, 1'b0, 2'd0, 6'd0, 8'h00);      // cursor restore only

      // Random phases, starting from the register extremes
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: set_config(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b1, 2'd3, 6'd63);
            1: set_config(8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, 2'd0, 6'd0);
            2: set_config(RST_EMPTY_CODE, RST_SKIP_CODE, RST_END_CODE,
                          1'b1, 1'b1, 1'b0, 2'd0, 6'd0);
            default: begin
               cur_skip = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
               cur_end  = ($urandom_range(0, 3) == 0) ? cur_skip : 8'($urandom);
               set_config(8'($urandom), cur_skip, cur_end, 1'($urandom), 1'($urandom),
                          1'($urandom), 2'($urandom), 6'($urandom));
            end
         endcase
         burst = ($urandom_range(0, 3) == 0);
         for (i = 0; i < PHASE_WORDS; i++) begin
            random_word();
            random_gap();
         end
         issue_word(FUNC_FLUSH, 1'($urandom), 2'($urandom), 6'($urandom), 8'($urandom));
      end

      // Let the last results come out, bounded
      @(negedge clock);
      start = 1'b0;
      guard = 0;
      while (due_count != 0 && guard < 10000) begin
         @(negedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d words over %0d register settings, %0d of them flushes;",
               words_taken, settings_done, flushes_taken);
      $display("%0d display writes compared, %0d failures, %0d writes never arrived.",
               writes_checked, errors, due_count);
      if (errors == 0 && due_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #4_000_000;
      $display("Timeout: stimulus or results stalled");
      $display("end of test: mismatches");
      $finish;
   end

endmodule
